// ----- hw/rtl/ssrr_pkg.sv -----
// Package for the serial speech ROM reader: sizes, stream word layouts and codes.
// Used by serial_speech_rom_reader and its testbench; depends on nothing.
`default_nettype none

package ssrr_pkg;

  // ROM and latch geometry.
  localparam int unsigned RomAddrBits  = 14;
  localparam int unsigned LatchNibbles = 5;

  localparam int unsigned RomDepth     = 1 << RomAddrBits;
  localparam int unsigned BankAddrBits = RomAddrBits - 1;
  localparam int unsigned BankDepth    = RomDepth / 2;
  localparam int unsigned BitAddrBits  = RomAddrBits + 3;
  localparam int unsigned LatchBits    = 4 * LatchNibbles;
  localparam int unsigned NibCntBits   = $clog2(LatchNibbles + 1);

  // A branch pointer is always 14 bits, whatever the ROM size.
  localparam int unsigned PtrBits      = 14;

  localparam int unsigned InDataBits   = 32;
  localparam int unsigned OutDataBits  = 8;

  // Mode lines as {M1, M0}.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'b00,
    MODE_READ   = 2'b01,
    MODE_LOAD   = 2'b10,
    MODE_BRANCH = 2'b11
  } mode_e;

  // Kind of an input word, carried on tuser.
  typedef enum logic {
    ACT_CLOCK = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  // Input tdata layout, first member in the highest bits.
  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] rom_byte;
    logic [13:0] rom_index;
    logic [3:0] addr_nibble;
    logic mode_high;
    logic mode_low;
  } in_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/serial_speech_rom_reader.sv -----
// Top level of the serial speech ROM reader: stream ports, control state and ROM banks.
// Depends on ssrr_pkg and ssrr_ram.
`default_nettype none

// Serial speech ROM reader. Each input word is either a falling edge of the
// ROM clock (tuser low), carrying the two mode lines and an address nibble,
// or a ROM byte write (tuser high). Every input word yields exactly one output
// word holding the serial data line level after it. The block sustains one
// word per clock cycle in both directions while the output is not stalled;
// a word's result goes from the execute register into the output register
// once the output register is free or drains in that cycle. The execute
// register is there for the ROM's registered read: the ROM is addressed on
// the accept edge and the word completes in the execute register. The ROM is
// split into an even and an odd bank so that the two pointer bytes of
// read-and-branch come out in the same cycle, and the bank addresses for the
// next word are taken from the next state of the word in execute, so no
// bubble is needed after a branch. Byte writes go to the ROM on their accept
// edge. The ROM has no reset: reading a byte that was never written returns
// an undefined value.
module serial_speech_rom_reader (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream.
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // Fields from bit 0: mode_low, mode_high, addr_nibble[3:0], rom_index[13:0],
  // rom_byte[7:0], zero padding.
  input  wire logic [ssrr_pkg::InDataBits-1:0]     s_axis_tdata_i,
  // Fields from bit 0: action.
  input  wire logic                                s_axis_tuser_i,
  // Output stream.
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // Fields from bit 0: data_bit, zero padding.
  output logic      [ssrr_pkg::OutDataBits-1:0]    m_axis_tdata_o
);

  // ---------------------------------------------------------------------------
  // Control state.
  // ---------------------------------------------------------------------------
  logic [ssrr_pkg::BitAddrBits-1:0] bit_addr_q, bit_addr_d;
  logic [ssrr_pkg::LatchBits-1:0]   latch_q, latch_d;
  logic [ssrr_pkg::NibCntBits-1:0]  nib_cnt_q, nib_cnt_d;
  logic                             read_pend_q, read_pend_d;
  logic                             dummy_q, dummy_d;
  logic                             out_bit_q, out_bit_d;

  // Execute register: the word whose ROM read is in flight.
  logic                      e_valid_q, e_valid_d;
  ssrr_pkg::action_e         e_action_q;
  ssrr_pkg::mode_e           e_mode_q;
  logic [3:0]                e_nibble_q;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic                      out_data_q;

  ssrr_pkg::in_word_t        in_word;
  ssrr_pkg::mode_e           in_mode;
  logic                      s_accept;
  logic                      e_go;

  assign in_word = ssrr_pkg::in_word_t'(s_axis_tdata_i);
  assign in_mode = ssrr_pkg::mode_e'({in_word.mode_high, in_word.mode_low});

  // The execute word moves on when the output register is free or drained
  // in this cycle; a new word enters whenever execute moves on or is empty.
  assign e_go            = e_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !e_valid_q || e_go;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // ROM banks: even byte addresses in one bank, odd ones in the other.
  // ---------------------------------------------------------------------------
  logic [ssrr_pkg::RomAddrBits-1:0]  wr_idx;
  logic [ssrr_pkg::RomAddrBits-1:0]  rd_x, rd_y;
  logic [ssrr_pkg::BankAddrBits-1:0] even_raddr, odd_raddr;
  logic                              rd_en, wr_en;
  logic [7:0]                        even_rdata, odd_rdata;

  assign wr_en  = s_accept && (ssrr_pkg::action_e'(s_axis_tuser_i) == ssrr_pkg::ACT_WRITE);
  assign rd_en  = s_accept && (ssrr_pkg::action_e'(s_axis_tuser_i) == ssrr_pkg::ACT_CLOCK);
  assign wr_idx = ssrr_pkg::RomAddrBits'(in_word.rom_index);

  // A branch reads the bytes at the latch and the one after it; a bit read
  // needs only the byte at the next bit address. Both come from the state
  // that the word in execute leaves behind.
  assign rd_x = (in_mode == ssrr_pkg::MODE_BRANCH) ? ssrr_pkg::RomAddrBits'(latch_d)
                                                   : bit_addr_d[ssrr_pkg::BitAddrBits-1:3];
  assign rd_y = rd_x + 1'b1;

  assign odd_raddr  = rd_x[ssrr_pkg::RomAddrBits-1:1];
  assign even_raddr = rd_x[0] ? rd_y[ssrr_pkg::RomAddrBits-1:1]
                              : rd_x[ssrr_pkg::RomAddrBits-1:1];

  ssrr_ram #(
    .Width (8),
    .Depth (ssrr_pkg::BankDepth)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (wr_en && !wr_idx[0]),
    .waddr_i (wr_idx[ssrr_pkg::RomAddrBits-1:1]),
    .wdata_i (in_word.rom_byte),
    .re_i    (rd_en),
    .raddr_i (even_raddr),
    .rdata_o (even_rdata)
  );

  ssrr_ram #(
    .Width (8),
    .Depth (ssrr_pkg::BankDepth)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (wr_en && wr_idx[0]),
    .waddr_i (wr_idx[ssrr_pkg::RomAddrBits-1:1]),
    .wdata_i (in_word.rom_byte),
    .re_i    (rd_en),
    .raddr_i (odd_raddr),
    .rdata_o (odd_rdata)
  );

  // ---------------------------------------------------------------------------
  // Execute: next control state for the word in the execute register.
  // The state registers still hold the state this word's read was issued
  // from, so bank parity comes from them.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [7:0]                   cur_byte;
    logic [7:0]                   ptr_lo;
    logic [7:0]                   ptr_hi;
    logic [ssrr_pkg::PtrBits-1:0] ptr;

    bit_addr_d  = bit_addr_q;
    latch_d     = latch_q;
    nib_cnt_d   = nib_cnt_q;
    read_pend_d = read_pend_q;
    dummy_d     = dummy_q;
    out_bit_d   = out_bit_q;

    cur_byte = bit_addr_q[3] ? odd_rdata : even_rdata;
    ptr_lo   = latch_q[0] ? odd_rdata : even_rdata;
    ptr_hi   = latch_q[0] ? even_rdata : odd_rdata;
    ptr      = ssrr_pkg::PtrBits'({ptr_hi, ptr_lo});

    if (e_go && (e_action_q == ssrr_pkg::ACT_CLOCK)) begin
      unique case (e_mode_q)
        ssrr_pkg::MODE_IDLE: begin
          if (read_pend_q) begin
            if (dummy_q) begin
              // Dummy read: the latch becomes the byte address.
              bit_addr_d = ssrr_pkg::BitAddrBits'(latch_q) << 3;
              latch_d    = '0;
              nib_cnt_d  = '0;
              dummy_d    = 1'b0;
            end else begin
              // Shift out one bit, most significant first.
              out_bit_d  = cur_byte[~bit_addr_q[2:0]];
              bit_addr_d = bit_addr_q + 1'b1;
            end
            read_pend_d = 1'b0;
          end
        end
        ssrr_pkg::MODE_READ: begin
          read_pend_d = 1'b1;
        end
        ssrr_pkg::MODE_LOAD: begin
          dummy_d = 1'b1;
          // Nibbles beyond a full latch are dropped.
          if (nib_cnt_q < ssrr_pkg::NibCntBits'(ssrr_pkg::LatchNibbles)) begin
            for (int i = 0; i < ssrr_pkg::LatchNibbles; i++) begin
              if (nib_cnt_q == ssrr_pkg::NibCntBits'(i)) begin
                latch_d[4*i +: 4] = latch_q[4*i +: 4] | e_nibble_q;
              end
            end
            nib_cnt_d = nib_cnt_q + 1'b1;
          end
        end
        ssrr_pkg::MODE_BRANCH: begin
          if (dummy_q) begin
            bit_addr_d = ssrr_pkg::BitAddrBits'(ptr) << 3;
            latch_d    = '0;
            nib_cnt_d  = '0;
            dummy_d    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control.
  // ---------------------------------------------------------------------------
  always_comb begin
    e_valid_d = e_valid_q;
    if (s_accept) begin
      e_valid_d = 1'b1;
    end else if (e_go) begin
      e_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (e_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_addr_q  <= '0;
      latch_q     <= '0;
      nib_cnt_q   <= '0;
      read_pend_q <= 1'b0;
      dummy_q     <= 1'b0;
      out_bit_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bit_addr_q  <= bit_addr_d;
      latch_q     <= latch_d;
      nib_cnt_q   <= nib_cnt_d;
      read_pend_q <= read_pend_d;
      dummy_q     <= dummy_d;
      out_bit_q   <= out_bit_d;
      e_valid_q   <= e_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      e_action_q <= ssrr_pkg::action_e'(s_axis_tuser_i);
      e_mode_q   <= in_mode;
      e_nibble_q <= in_word.addr_nibble;
    end
    if (e_go) begin
      out_data_q <= out_bit_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ssrr_pkg::OutDataBits'(out_data_q);

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An empty latch count means an empty latch.
  a_latch_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nib_cnt_q == '0) |-> (latch_q == '0))
    else $error("latch holds bits while its nibble count is zero");

  // Input is refused only while execute is full and the output is stalled.
  a_ready_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (e_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  // A completed word always lands in the output register.
  a_result_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_go |=> (out_valid_q && (out_data_q == out_bit_q)))
    else $error("completed word did not reach the output register");

  // A ROM write leaves the data line unchanged.
  a_write_keeps_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_go && (e_action_q == ssrr_pkg::ACT_WRITE)) |=> (out_data_q == $past(out_bit_q)))
    else $error("ROM write changed the data line");

  // A load-address edge always arms the dummy read.
  a_load_arms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_go && (e_action_q == ssrr_pkg::ACT_CLOCK) && (e_mode_q == ssrr_pkg::MODE_LOAD))
    |=> dummy_q)
    else $error("load address did not arm the dummy read");

endmodule

`default_nettype wire

// ----- hw/rtl/ssrr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the ROM banks of the serial speech ROM reader.
`default_nettype none

module ssrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/serial_speech_rom_reader_tb.sv -----
// Self-checking testbench for the serial speech ROM reader: directed and random
// streams of clock edges and ROM writes, checked word by word against a predictor.
// Depends on ssrr_pkg and the serial_speech_rom_reader RTL.

module serial_speech_rom_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 1600;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 20;

  // Predicts the serial data line after every input word and keeps the
  // bits still owed by the block in arrival order.
  class serial_bit_scoreboard;
    logic [7:0]                       rom_img [ssrr_pkg::RomDepth];
    bit                               written [ssrr_pkg::RomDepth];
    logic [ssrr_pkg::BitAddrBits-1:0] bit_addr;
    logic [ssrr_pkg::LatchBits-1:0]   latch;
    int unsigned                      nib_cnt;
    bit                               rd_pend;
    bit                               dummy_pend;
    bit                               out_bit;
    bit                               bits_due [$];
    int unsigned                      errors;
    int unsigned                      n_writes;
    int unsigned                      n_shifted;
    int unsigned                      n_addr_loads;
    int unsigned                      n_branches;
    int unsigned                      n_dropped;
    int unsigned                      n_checked;

    function new();
      bit_addr   = '0;
      latch      = '0;
      nib_cnt    = 0;
      rd_pend    = 1'b0;
      dummy_pend = 1'b0;
      out_bit    = 1'b0;
    endfunction

    function void note_word(ssrr_pkg::action_e act, ssrr_pkg::in_word_t w);
      ssrr_pkg::mode_e                  m;
      logic [ssrr_pkg::RomAddrBits-1:0] lo;
      logic [ssrr_pkg::RomAddrBits-1:0] hi;
      logic [15:0]                      ptr;
      logic [7:0]                       cur;
      if (act == ssrr_pkg::ACT_WRITE) begin
        rom_img[w.rom_index[ssrr_pkg::RomAddrBits-1:0]] = w.rom_byte;
        written[w.rom_index[ssrr_pkg::RomAddrBits-1:0]] = 1'b1;
        n_writes++;
      end else begin
        m = ssrr_pkg::mode_e'({w.mode_high, w.mode_low});
        case (m)
          ssrr_pkg::MODE_IDLE: begin
            if (rd_pend) begin
              if (dummy_pend) begin
                // The dummy read moves the latch into the bit address.
                bit_addr   = ssrr_pkg::BitAddrBits'({latch, 3'b000});
                latch      = '0;
                nib_cnt    = 0;
                dummy_pend = 1'b0;
                n_addr_loads++;
              end else begin
                // MSB of the byte comes out first.
                cur      = rom_img[bit_addr[ssrr_pkg::BitAddrBits-1:3]];
                out_bit  = cur[~bit_addr[2:0]];
                bit_addr = bit_addr + 1'b1;
                n_shifted++;
              end
              rd_pend = 1'b0;
            end
          end
          ssrr_pkg::MODE_READ: begin
            rd_pend = 1'b1;
          end
          ssrr_pkg::MODE_LOAD: begin
            dummy_pend = 1'b1;
            if (nib_cnt < ssrr_pkg::LatchNibbles) begin
              latch   = latch | (ssrr_pkg::LatchBits'(w.addr_nibble) << (4 * nib_cnt));
              nib_cnt++;
            end else begin
              n_dropped++;
            end
          end
          ssrr_pkg::MODE_BRANCH: begin
            if (dummy_pend) begin
              lo         = latch[ssrr_pkg::RomAddrBits-1:0];
              hi         = lo + 1'b1;
              ptr        = {rom_img[hi], rom_img[lo]};
              bit_addr   = ssrr_pkg::BitAddrBits'({ptr[ssrr_pkg::PtrBits-1:0], 3'b000});
              latch      = '0;
              nib_cnt    = 0;
              dummy_pend = 1'b0;
              n_branches++;
            end
          end
          default: ;
        endcase
      end
      bits_due.push_back(out_bit);
    endfunction

    function void check_word(logic [ssrr_pkg::OutDataBits-1:0] d);
      bit exp_bit;
      if (bits_due.size() == 0) begin
        $error("output word %0h arrived with no word outstanding", d);
        errors++;
      end else begin
        exp_bit = bits_due.pop_front();
        n_checked++;
        if (d[0] !== exp_bit) begin
          $error("data_bit mismatch: expected %0d, got %0d", exp_bit, d[0]);
          errors++;
        end
        if (d[ssrr_pkg::OutDataBits-1:1] !== '0) begin
          $error("pad mismatch: expected 0, got %0h", d[ssrr_pkg::OutDataBits-1:1]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic [ssrr_pkg::InDataBits-1:0]  s_axis_tdata_i  = '0;
  logic                             s_axis_tuser_i  = ssrr_pkg::ACT_CLOCK;
  logic                             m_axis_tready_i = 1'b0;
  logic                             s_axis_tready_o;
  logic                             m_axis_tvalid_o;
  logic [ssrr_pkg::OutDataBits-1:0] m_axis_tdata_o;

  serial_bit_scoreboard sb = new();

  // While calm is set neither side inserts gaps.
  bit          calm;
  int unsigned words_sent;
  int unsigned stall_left;
  int unsigned idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  serial_speech_rom_reader u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Mostly no gap, some short ones and an occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic ssrr_pkg::in_word_t make_word(logic [1:0] mode, logic [3:0] nib,
                                                   logic [13:0] idx, logic [7:0] val);
    ssrr_pkg::in_word_t w;
    w.pad         = '0;
    w.rom_byte    = val;
    w.rom_index   = idx;
    w.addr_nibble = nib;
    w.mode_high   = mode[1];
    w.mode_low    = mode[0];
    return w;
  endfunction

  // Offers one word, waits for the handshake, records it, then maybe idles.
  task automatic put_word(ssrr_pkg::action_e act, ssrr_pkg::in_word_t w);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(act, w);
    words_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic do_write(logic [ssrr_pkg::RomAddrBits-1:0] idx, logic [7:0] val);
    put_word(ssrr_pkg::ACT_WRITE, make_word(2'($urandom), 4'($urandom), 14'(idx), val));
  endtask

  task automatic fill_byte(logic [ssrr_pkg::RomAddrBits-1:0] idx);
    if (!sb.written[idx]) do_write(idx, 8'($urandom));
  endtask

  // The ROM powers up with unknown contents, so any byte the next edge is
  // going to read gets written first.
  task automatic do_edge(ssrr_pkg::mode_e m, logic [3:0] nib);
    logic [ssrr_pkg::RomAddrBits-1:0] lo;
    lo = sb.latch[ssrr_pkg::RomAddrBits-1:0];
    if (m == ssrr_pkg::MODE_IDLE && sb.rd_pend && !sb.dummy_pend)
      fill_byte(sb.bit_addr[ssrr_pkg::BitAddrBits-1:3]);
    if (m == ssrr_pkg::MODE_BRANCH && sb.dummy_pend) begin
      fill_byte(lo);
      fill_byte(lo + 1'b1);
    end
    put_word(ssrr_pkg::ACT_CLOCK, make_word(m, nib, 14'($urandom), 8'($urandom)));
  endtask

  // Shifts out k bits; now and then the byte under the read pointer is
  // rewritten just before the edge that reads it.
  task automatic read_bits(int unsigned k);
    repeat (k) begin
      do_edge(ssrr_pkg::MODE_READ, 4'($urandom));
      if ($urandom_range(0, 7) == 0 && !sb.dummy_pend)
        do_write(sb.bit_addr[ssrr_pkg::BitAddrBits-1:3], 8'($urandom));
      do_edge(ssrr_pkg::MODE_IDLE, 4'($urandom));
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.bits_due.size() != 0);
  endtask

  // Receiver: checks every accepted word and stalls at random.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no word moved for %0d cycles", idle_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [ssrr_pkg::RomAddrBits-1:0] target;
    logic [3:0]                       nib;
    int unsigned                      kind;
    int unsigned                      how;
    int unsigned                      n_nibs;
    int unsigned                      r;
    bit                               rand_nibs;
    bit                               drained_once;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: byte extremes, both ends of the ROM, every mode.
    do_write(14'h3fff, 8'hff);
    do_write(14'h0000, 8'hff);
    do_write(14'h0001, 8'h00);
    do_write(14'h0002, 8'h80);
    do_edge(ssrr_pkg::MODE_IDLE, 4'h0);                 // nothing pending: no change
    do_edge(ssrr_pkg::MODE_READ, 4'h0);
    do_edge(ssrr_pkg::MODE_IDLE, 4'hf);                 // first bit of byte 0
    do_edge(ssrr_pkg::MODE_BRANCH, 4'h0);               // no dummy read armed: ignored
    repeat (6) do_edge(ssrr_pkg::MODE_LOAD, 4'hf);      // the sixth nibble is dropped
    do_edge(ssrr_pkg::MODE_BRANCH, 4'h0);               // pointer bytes wrap past the top
    do_edge(ssrr_pkg::MODE_READ, 4'h0);
    do_edge(ssrr_pkg::MODE_IDLE, 4'h0);
    do_edge(ssrr_pkg::MODE_LOAD, 4'h1);
    do_edge(ssrr_pkg::MODE_READ, 4'h0);
    do_edge(ssrr_pkg::MODE_BRANCH, 4'h0);               // read stays pending over a branch
    do_edge(ssrr_pkg::MODE_IDLE, 4'h0);
    do_edge(ssrr_pkg::MODE_LOAD, 4'h0);
    do_edge(ssrr_pkg::MODE_READ, 4'h0);
    do_edge(ssrr_pkg::MODE_IDLE, 4'h0);                 // dummy read loads the address

    drained_once = 1'b0;
    while (words_sent < RandomWords) begin
      if ($urandom_range(0, 5) == 0) calm = !calm;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // Address load, then a dummy read or a branch, then a bit stream.
        r = $urandom_range(0, 9);
        if (r < 4) target = $urandom_range(0, 1) ? 14'($urandom_range(16368, 16383))
                                                 : 14'($urandom_range(0, 15));
        else if (r < 7) target = 14'($urandom_range(0, 511));
        else target = 14'($urandom);
        r = $urandom_range(0, 9);
        rand_nibs = (r >= 8);
        n_nibs = (r < 6) ? ssrr_pkg::LatchNibbles : (r < 8) ? $urandom_range(6, 8)
                                                            : $urandom_range(1, 4);
        for (int i = 0; i < n_nibs; i++) begin
          case (i)
            0: nib = target[3:0];
            1: nib = target[7:4];
            2: nib = target[11:8];
            3: nib = {2'($urandom), target[13:12]};
            default: nib = 4'($urandom);
          endcase
          if (rand_nibs) nib = 4'($urandom);
          do_edge(ssrr_pkg::MODE_LOAD, nib);
        end
        how = $urandom_range(0, 19);
        if (how < 10) begin
          do_edge(ssrr_pkg::MODE_READ, 4'($urandom));
          do_edge(ssrr_pkg::MODE_IDLE, 4'($urandom));
        end else if (how < 17) begin
          if ($urandom_range(0, 5) == 0)
            do_write(sb.latch[ssrr_pkg::RomAddrBits-1:0], 8'($urandom));
          do_edge(ssrr_pkg::MODE_BRANCH, 4'($urandom));
        end else begin
          do_edge(ssrr_pkg::MODE_READ, 4'($urandom));
          do_edge(ssrr_pkg::MODE_BRANCH, 4'($urandom));
          do_edge(ssrr_pkg::MODE_IDLE, 4'($urandom));
        end
        read_bits(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8));
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 2);
          target = (r == 0) ? 14'($urandom_range(0, 511)) : (r == 1) ?
                   14'($urandom_range(16368, 16383)) : 14'($urandom);
          do_write(target, 8'($urandom));
        end
      end else if (kind < 75) begin
        read_bits($urandom_range(1, 10));
      end else begin
        // Noise: any word in any order.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) do_write(14'($urandom), 8'($urandom));
          else do_edge(ssrr_pkg::mode_e'($urandom_range(0, 3)), 4'($urandom));
        end
      end
      if ((!drained_once && words_sent > RandomWords / 2) || $urandom_range(0, 39) == 0) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
    end

    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d words: %0d ROM writes, %0d bits shifted out, %0d checked.",
             words_sent, sb.n_writes, sb.n_shifted, sb.n_checked);
    $display("Address loads %0d, branches %0d, dropped nibbles %0d.",
             sb.n_addr_loads, sb.n_branches, sb.n_dropped);
    if (sb.errors == 0 && sb.bits_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.bits_due.size() != 0)
        $error("%0d output words never arrived", sb.bits_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
